// File: src/pcg_pkg.sv
// Shared constants for the PCG32 (XSH-RR) generator.
// No dependencies; used by every module under src.
package pcg_pkg;

  localparam int unsigned STATE_W = 64;
  localparam int unsigned HALF_W  = 32;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned STREAM_W = 63;

  localparam logic [STATE_W-1:0] LCG_MULT = 64'd6364136223846793005;
  localparam logic [WORD_W-1:0]  RANGE_LIMIT = 32'd2147483647;

  localparam int unsigned XSH_SHIFT = 18;
  localparam int unsigned MIX_LSB   = 27;
  localparam int unsigned ROT_LSB   = 59;
  localparam int unsigned ROT_W     = 5;

  // APB register map
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam logic REG_IDX_REDUCE = 1'b0;
  localparam logic REDUCE_RESET   = 1'b1;

  // Multiplier operand selects, one per phase of an LCG step
  typedef enum logic [1:0] {
    MUL_LO_LO = 2'd0,
    MUL_LO_HI = 2'd1,
    MUL_HI_LO = 2'd2,
    MUL_NONE  = 2'd3
  } mul_phase_t;

endpackage

// File: src/pcg_mul.sv
// Shared 32x32 multiplier with a registered 64-bit product.
// Depends on pcg_pkg for widths.
module pcg_mul (
  input  logic                              clk,
  input  logic [pcg_pkg::HALF_W-1:0]        a,
  input  logic [pcg_pkg::HALF_W-1:0]        b,
  output logic [2*pcg_pkg::HALF_W-1:0]      p
);

  always_ff @(posedge clk) begin
    p <= {{pcg_pkg::HALF_W{1'b0}}, a} * {{pcg_pkg::HALF_W{1'b0}}, b};
  end

endmodule

// File: src/pcg_perm.sv
// XSH-RR output permutation and optional reduction modulo 2^31-1.
// Depends on pcg_pkg for field positions and the range limit.
module pcg_perm (
  input  logic [pcg_pkg::STATE_W-1:0] old_state,
  input  logic                        reduce,
  output logic [pcg_pkg::WORD_W-1:0]  value
);

  logic [pcg_pkg::STATE_W-1:0]  xs;
  logic [pcg_pkg::WORD_W-1:0]   mixed;
  logic [pcg_pkg::ROT_W-1:0]    rot;
  logic [2*pcg_pkg::WORD_W-1:0] doubled;
  logic [pcg_pkg::WORD_W-1:0]   word;
  logic [pcg_pkg::WORD_W-1:0]   folded;

  always_comb begin
    xs      = old_state ^ (old_state >> pcg_pkg::XSH_SHIFT);
    mixed   = xs[pcg_pkg::MIX_LSB +: pcg_pkg::WORD_W];
    rot     = old_state[pcg_pkg::ROT_LSB +: pcg_pkg::ROT_W];
    doubled = {mixed, mixed} >> rot;
    word    = doubled[pcg_pkg::WORD_W-1:0];
    // 2^31 is 1 mod 2^31-1: fold the top bit back in, then one subtract
    folded  = {1'b0, word[pcg_pkg::WORD_W-2:0]}
            + {{(pcg_pkg::WORD_W-1){1'b0}}, word[pcg_pkg::WORD_W-1]};
    if (folded >= pcg_pkg::RANGE_LIMIT) begin
      folded = folded - pcg_pkg::RANGE_LIMIT;
    end
    value = reduce ? folded : word;
  end

endmodule

// File: src/pcg32_random_generator.sv
// PCG32 XSH-RR generator: LCG steps on a shared multiplier, result permuted and registered.
// One LCG step runs on the shared 32x32 multiplier (three partial products,
// registered); a draw is one step, a reseed two. One word in flight:
// s_tready is high only while the sequencer idles; a result waits for a free output register.
// Synchronous active-high reset: state 0, increment 1, reduce_range 1.
module pcg32_random_generator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [127:0]                 s_tdata,  // [63:0] seed_state, [126:64] seed_stream
  input  logic                         s_tuser,  // [0] mode
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [pcg_pkg::WORD_W-1:0]   m_tdata,  // [31:0] value
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pcg_pkg::PADDR_W-1:0]  paddr,
  input  logic [pcg_pkg::PDATA_W-1:0]  pwdata,
  output logic [pcg_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_LCG, ST_DONE} state_t;

  state_t                        state;
  logic [1:0]                    phase;
  logic                          seed_pass;
  logic [pcg_pkg::STATE_W-1:0]   gen_state;
  logic [pcg_pkg::STATE_W-1:0]   stream_step;
  logic [pcg_pkg::STATE_W-1:0]   old_state;
  logic [pcg_pkg::STATE_W-1:0]   acc;
  logic                          reduce_range;

  logic [pcg_pkg::HALF_W-1:0]    mul_a;
  logic [pcg_pkg::HALF_W-1:0]    mul_b;
  logic [2*pcg_pkg::HALF_W-1:0]  prod;
  logic [pcg_pkg::WORD_W-1:0]    perm_value;
  logic [pcg_pkg::HALF_W-1:0]    hi_sum;
  logic [pcg_pkg::STATE_W-1:0]   seed_inc;
  logic                          s_accept;
  logic                          m_accept;
  logic                          cfg_write;

  assign s_tready  = (state == ST_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign m_accept  = m_tvalid && m_tready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == pcg_pkg::REG_IDX_REDUCE)
                   ? {{(pcg_pkg::PDATA_W-1){1'b0}}, reduce_range} : '0;

  assign seed_inc = {s_tdata[126:64], 1'b1};
  assign hi_sum   = acc[pcg_pkg::STATE_W-1:pcg_pkg::HALF_W] + prod[pcg_pkg::HALF_W-1:0];

  // operand select for the three partial products of state * multiplier
  always_comb begin
    unique case (pcg_pkg::mul_phase_t'(phase))
      pcg_pkg::MUL_LO_LO: begin
        mul_a = gen_state[pcg_pkg::HALF_W-1:0];
        mul_b = pcg_pkg::LCG_MULT[pcg_pkg::HALF_W-1:0];
      end
      pcg_pkg::MUL_LO_HI: begin
        mul_a = gen_state[pcg_pkg::HALF_W-1:0];
        mul_b = pcg_pkg::LCG_MULT[pcg_pkg::STATE_W-1:pcg_pkg::HALF_W];
      end
      pcg_pkg::MUL_HI_LO: begin
        mul_a = gen_state[pcg_pkg::STATE_W-1:pcg_pkg::HALF_W];
        mul_b = pcg_pkg::LCG_MULT[pcg_pkg::HALF_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pcg_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  pcg_perm u_perm (
    .old_state (old_state),
    .reduce    (reduce_range),
    .value     (perm_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reduce_range <= pcg_pkg::REDUCE_RESET;
    end else if (cfg_write && paddr[2] == pcg_pkg::REG_IDX_REDUCE) begin
      reduce_range <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= 2'd0;
      seed_pass   <= 1'b0;
      gen_state   <= '0;
      stream_step <= 64'd1;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_accept && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          phase <= 2'd0;
          if (s_accept) begin
            state <= ST_LCG;
            if (s_tuser) begin
              // first LCG step from zero state leaves just the increment
              stream_step <= seed_inc;
              gen_state   <= seed_inc + s_tdata[63:0];
              seed_pass   <= 1'b1;
            end else begin
              old_state <= gen_state;
              seed_pass <= 1'b0;
            end
          end
        end
        ST_LCG: begin
          phase <= phase + 2'd1;
          unique case (phase)
            2'd0: ;
            2'd1: acc <= prod + stream_step;
            2'd2: acc[pcg_pkg::STATE_W-1:pcg_pkg::HALF_W] <= hi_sum;
            default: begin
              gen_state <= {hi_sum, acc[pcg_pkg::HALF_W-1:0]};
              if (seed_pass) begin
                seed_pass <= 1'b0;
                old_state <= {hi_sum, acc[pcg_pkg::HALF_W-1:0]};
              end else begin
                state <= ST_DONE;
              end
            end
          endcase
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= perm_value;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: src/pcg_checker.sv
// Port-level checks for pcg32_random_generator, bound to the top level.
// Depends on pcg_pkg for the range limit and register index.
module pcg_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [pcg_pkg::WORD_W-1:0]   m_tdata,
  input logic                         psel,
  input logic                         pwrite,
  input logic [pcg_pkg::PADDR_W-1:0]  paddr,
  input logic [pcg_pkg::PDATA_W-1:0]  prdata
);

  // one word in flight: the input side closes right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a word is in flight");

  // a draw needs the full multiply sequence before its result appears
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid ##1 !m_tvalid ##1 !m_tvalid)
    else $error("result appeared before the LCG step completed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  // checked while reduction reads back as on: a valid result is below 2^31-1
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    psel && !pwrite && paddr[2] == pcg_pkg::REG_IDX_REDUCE && prdata[0] && m_tvalid
      |-> m_tdata < pcg_pkg::RANGE_LIMIT)
    else $error("reduced result out of range");

endmodule

bind pcg32_random_generator pcg_checker u_pcg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .psel     (psel),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .prdata   (prdata)
);

// File: test/testbench.sv
// Self-checking testbench for the PCG32 XSH-RR generator: a directed table, then random
// phases that change reduce_range over APB, checked against typed values or an in-bench predictor.
// Depends on src/pcg_pkg.sv and src/pcg32_random_generator.sv.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {
    MODE_DRAW = 1'b0,
    MODE_SEED = 1'b1
  } gen_mode_e;

  typedef struct packed {
    gen_mode_e                    mode;
    logic [pcg_pkg::STATE_W-1:0]  seed_state;
    logic [pcg_pkg::STREAM_W-1:0] seed_stream;
    logic                         known;
    logic [pcg_pkg::WORD_W-1:0]   value;
  } plan_row_t;

  // register index 1 has no register behind it
  localparam logic REG_IDX_UNUSED = 1'b1;
  localparam logic [pcg_pkg::PADDR_W-1:0] REDUCE_ADDR = {pcg_pkg::REG_IDX_REDUCE, 2'b00};
  localparam logic [pcg_pkg::PADDR_W-1:0] UNUSED_ADDR = {REG_IDX_UNUSED, 2'b00};

  localparam logic [pcg_pkg::STATE_W-1:0]  ONES64 = '1;
  localparam logic [pcg_pkg::STREAM_W-1:0] ONES63 = '1;

  localparam int PLAN_LEN    = 16;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 192;
  localparam int TAIL_CYCLES = 16;

  // From reset the state walks 0 -> 1, both of which permute to zero.
  localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
    '{MODE_DRAW, 64'd0, 63'd0, 1'b1, 32'd0},
    '{MODE_DRAW, ONES64, ONES63, 1'b1, 32'd0},
    '{MODE_DRAW, 64'd0, 63'd0, 1'b0, 32'd0},
    '{MODE_SEED, 64'd0, 63'd0, 1'b0, 32'd0},
    '{MODE_DRAW, 64'd0, 63'd0, 1'b0, 32'd0},
    '{MODE_SEED, ONES64, ONES63, 1'b0, 32'd0},
    '{MODE_DRAW, 64'd0, ONES63, 1'b0, 32'd0},
    '{MODE_DRAW, ONES64, 63'd0, 1'b0, 32'd0},
    '{MODE_SEED, 64'd0, ONES63, 1'b0, 32'd0},
    '{MODE_DRAW, 64'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 32'd0},
    '{MODE_SEED, ONES64, 63'd0, 1'b0, 32'd0},
    '{MODE_DRAW, 64'd0, 63'd0, 1'b0, 32'd0},
    '{MODE_SEED, 64'hAAAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 1'b0, 32'd0},
    '{MODE_DRAW, 64'd0, 63'd0, 1'b0, 32'd0},
    '{MODE_SEED, 64'h8000_0000_0000_0001, 63'h4000_0000_0000_0001, 1'b0, 32'd0},
    '{MODE_DRAW, 64'd0, 63'd0, 1'b0, 32'd0}
  };

  logic                          clk      = 1'b0;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [127:0]                  s_tdata  = '0;  // [63:0] seed_state, [126:64] seed_stream
  logic                          s_tuser  = 1'b0;  // [0] mode
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [pcg_pkg::WORD_W-1:0]    m_tdata;  // [31:0] value
  logic                          psel     = 1'b0;
  logic                          penable  = 1'b0;
  logic                          pwrite   = 1'b0;
  logic [pcg_pkg::PADDR_W-1:0]   paddr    = '0;
  logic [pcg_pkg::PDATA_W-1:0]   pwdata   = '0;
  logic [pcg_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  // Predictor state
  logic [pcg_pkg::STATE_W-1:0] lcg_state;
  logic [pcg_pkg::STATE_W-1:0] lcg_inc;
  logic                        reduce_cfg;

  logic [pcg_pkg::WORD_W-1:0] words_due [$];
  bit                tx_idle_on = 1'b0;
  bit                rx_idle_on = 1'b0;
  int unsigned       rx_wait    = 0;
  int unsigned       mismatches = 0;
  int unsigned       words_seen = 0;
  int unsigned       draws_sent = 0;
  int unsigned       seeds_sent = 0;
  int unsigned       cfg_writes = 0;

  pcg32_random_generator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic logic [pcg_pkg::STATE_W-1:0] lcg_step(
      input logic [pcg_pkg::STATE_W-1:0] s);
    return s * pcg_pkg::LCG_MULT + lcg_inc;
  endfunction

  // Advance the predicted generator by one item and return the word it emits.
  function automatic logic [pcg_pkg::WORD_W-1:0] next_value(
      input gen_mode_e mode,
      input logic [pcg_pkg::STATE_W-1:0] sst,
      input logic [pcg_pkg::STREAM_W-1:0] sstr);
    logic [pcg_pkg::STATE_W-1:0] old;
    logic [pcg_pkg::STATE_W-1:0] xs;
    logic [pcg_pkg::WORD_W-1:0]  mixed;
    logic [pcg_pkg::WORD_W-1:0]  word;
    logic [pcg_pkg::ROT_W-1:0]   rot;
    logic [pcg_pkg::ROT_W-1:0]   lrot;
    if (mode == MODE_SEED) begin
      lcg_inc   = {sstr, 1'b1};
      lcg_state = lcg_step('0);
      lcg_state = lcg_step(lcg_state + sst);
    end
    old       = lcg_state;
    lcg_state = lcg_step(old);
    xs        = ((old >> pcg_pkg::XSH_SHIFT) ^ old) >> pcg_pkg::MIX_LSB;
    mixed     = xs[pcg_pkg::WORD_W-1:0];
    rot       = old[pcg_pkg::ROT_LSB +: pcg_pkg::ROT_W];
    lrot      = -rot;
    word      = (mixed >> rot) | (mixed << lrot);
    if (reduce_cfg && word >= pcg_pkg::RANGE_LIMIT)
      word = word % pcg_pkg::RANGE_LIMIT;
    return word;
  endfunction

  function automatic logic [pcg_pkg::STATE_W-1:0] pick_wide();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Result side: check each accepted word, then draw the stall before the next one.
  always @(posedge clk) begin : value_sink
    logic [pcg_pkg::WORD_W-1:0] want;
    if (rst) begin
      rx_wait = 0;
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (words_due.size() == 0) begin
          $error("unexpected word: value actual %h", m_tdata);
          mismatches++;
        end else begin
          want = words_due.pop_front();
          words_seen++;
          if (m_tdata !== want) begin
            $error("value mismatch: expected %h, actual %h", want, m_tdata);
            mismatches++;
          end
        end
        rx_wait = rx_idle_on ? $urandom_range(0, 19) : 0;
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      m_tready <= (rx_wait == 0);
    end
  end

  task automatic send_word(input gen_mode_e mode,
                           input logic [pcg_pkg::STATE_W-1:0] sst,
                           input logic [pcg_pkg::STREAM_W-1:0] sstr, input logic known,
                           input logic [pcg_pkg::WORD_W-1:0] typed);
    int unsigned                gap;
    logic [pcg_pkg::WORD_W-1:0] want;
    gap = tx_idle_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {1'b0, sstr, sst};
    do @(posedge clk); while (!s_tready);
    want = next_value(mode, sst, sstr);
    words_due.push_back(known ? typed : want);
    if (mode == MODE_SEED) seeds_sent++;
    else draws_sent++;
  endtask

  // Hold off the sender until every outstanding word has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [pcg_pkg::PADDR_W-1:0] addr,
                            input logic [pcg_pkg::PDATA_W-1:0] wdata,
                            output logic [pcg_pkg::PDATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_setting();
    logic [pcg_pkg::PDATA_W-1:0] rd;
    logic [pcg_pkg::PDATA_W-1:0] exp_rd;
    exp_rd = {{(pcg_pkg::PDATA_W-1){1'b0}}, reduce_cfg};
    apb_access(1'b0, REDUCE_ADDR, '0, rd);
    if (rd !== exp_rd) begin
      $error("reduce_range readback mismatch: expected %h, actual %h", exp_rd, rd);
      mismatches++;
    end
  endtask

  task automatic write_setting(input logic [pcg_pkg::PADDR_W-1:0] addr,
                               input logic [pcg_pkg::PDATA_W-1:0] wdata);
    logic [pcg_pkg::PDATA_W-1:0] rd;
    apb_access(1'b1, addr, wdata, rd);
    if (addr == REDUCE_ADDR) reduce_cfg = wdata[0];
    cfg_writes++;
  endtask

  initial begin : stimulus
    gen_mode_e                   mode;
    logic [pcg_pkg::STATE_W-1:0] sst;
    logic [pcg_pkg::STATE_W-1:0] wide;
    logic [pcg_pkg::PDATA_W-1:0] wdata;
    lcg_state  = '0;
    lcg_inc    = 64'd1;
    reduce_cfg = pcg_pkg::REDUCE_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    check_setting();
    foreach (DIRECTED_PLAN[i])
      send_word(DIRECTED_PLAN[i].mode, DIRECTED_PLAN[i].seed_state,
                DIRECTED_PLAN[i].seed_stream, DIRECTED_PLAN[i].known,
                DIRECTED_PLAN[i].value);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      // Alternate the setting; junk in the upper bits must be dropped.
      wdata    = $urandom();
      wdata[0] = p[0] ? 1'b1 : 1'b0;
      if (p == 0) wdata = '1 ^ 32'd1;
      write_setting(REDUCE_ADDR, wdata);
      write_setting(UNUSED_ADDR, $urandom());
      check_setting();
      tx_idle_on = p[0];
      rx_idle_on = p[1];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        mode = ($urandom_range(0, 4) == 0) ? MODE_SEED : MODE_DRAW;
        sst  = pick_wide();
        wide = pick_wide();
        send_word(mode, sst, wide[pcg_pkg::STREAM_W-1:0], 1'b0, '0);
        if ($urandom_range(0, 63) == 0) drain();
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("summary: %0d draws, %0d reseeds, %0d words checked, %0d register writes",
             draws_sent, seeds_sent, words_seen, cfg_writes);
    $display("summary: reduce_range toggled across %0d phases with mixed idle patterns",
             PHASES);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
